### hw/rtl/pwsp_pkg.sv
// ----------------------------------------------------------------------------
// pwsp_pkg
// Shared types and constants of the packet and word stream parser.
// ----------------------------------------------------------------------------
package pwsp_pkg;

   localparam int WORD_MAX = 32;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] SUM_BASE   = 8'hFF;

   localparam logic [2:0] PH_WAIT   = 3'd0;
   localparam logic [2:0] PH_WORD   = 3'd1;
   localparam logic [2:0] PH_OP     = 3'd2;
   localparam logic [2:0] PH_SENDER = 3'd3;
   localparam logic [2:0] PH_LENGTH = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;
   localparam logic [2:0] PH_CHECK  = 3'd6;

   localparam logic [1:0] RESP_PARSING = 2'd0;
   localparam logic [1:0] RESP_START   = 2'd1;
   localparam logic [1:0] RESP_WORD    = 2'd2;
   localparam logic [1:0] RESP_PACKET  = 2'd3;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] data_sum;
      logic [7:0] data_count;
      logic [7:0] header_op;
      logic [7:0] header_sender;
      logic [7:0] header_length;
      logic [5:0] word_count;
   } state_type;

   typedef struct packed {
      logic [1:0] response;
      logic [7:0] packet_op;
      logic [7:0] packet_sender;
      logic [7:0] packet_length;
      logic       data_valid;
      logic [7:0] data_index;
      logic [7:0] data_byte;
      logic       word_char_valid;
      logic [4:0] word_index;
      logic [7:0] word_char;
      logic [5:0] word_length;
   } result_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

### hw/rtl/pwsp_if.sv
// ----------------------------------------------------------------------------
// pwsp_req_if / pwsp_rsp_if
// Valid/ready channels for received bytes and parse results.
// ----------------------------------------------------------------------------
interface pwsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pwsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] response;
   logic [7:0] packet_op;
   logic [7:0] packet_sender;
   logic [7:0] packet_length;
   logic       data_valid;
   logic [7:0] data_index;
   logic [7:0] data_byte;
   logic       word_char_valid;
   logic [4:0] word_index;
   logic [7:0] word_char;
   logic [5:0] word_length;

   modport source (output valid, output response, output packet_op,
                   output packet_sender, output packet_length, output data_valid,
                   output data_index, output data_byte, output word_char_valid,
                   output word_index, output word_char, output word_length,
                   input ready);
   modport sink (input valid, input response, input packet_op,
                 input packet_sender, input packet_length, input data_valid,
                 input data_index, input data_byte, input word_char_valid,
                 input word_index, input word_char, input word_length,
                 output ready);
endinterface

### hw/rtl/pwsp_step.sv
// ----------------------------------------------------------------------------
// pwsp_step
// Next parser state and result for one received byte.
// ----------------------------------------------------------------------------
module pwsp_step (
   input  pwsp_pkg::state_type  state,
   input  logic [7:0]           rx_byte,
   output pwsp_pkg::state_type  state_next,
   output pwsp_pkg::result_type result
);
   import pwsp_pkg::*;

   logic [7:0] count_inc;
   logic       alnum;
   logic       word_room;

   assign count_inc = state.data_count + 8'd1;
   assign alnum     = is_alnum(rx_byte);
   assign word_room = {2'b00, state.word_count} < 8'(WORD_MAX);

   always_comb begin
      state_next             = state;
      result                 = '0;
      result.response        = RESP_PARSING;
      if (state.phase != PH_CHECK && rx_byte == START_BYTE) begin
         state_next          = '0;
         state_next.phase    = PH_OP;
         result.response     = RESP_START;
      end else begin
         case (state.phase)
            PH_WAIT: begin
               if (alnum) begin
                  result.word_char_valid = 1'b1;
                  result.word_char       = rx_byte;
                  state_next.word_count  = 6'd1;
                  state_next.phase       = PH_WORD;
               end
            end
            PH_WORD: begin
               if (alnum) begin
                  if (word_room) begin
                     result.word_char_valid = 1'b1;
                     result.word_index      = state.word_count[4:0];
                     result.word_char       = rx_byte;
                     state_next.word_count  = state.word_count + 6'd1;
                  end
               end else begin
                  result.response       = RESP_WORD;
                  result.word_length    = state.word_count;
                  state_next.word_count = '0;
                  state_next.phase      = PH_WAIT;
               end
            end
            PH_OP: begin
               state_next.header_op = rx_byte;
               state_next.phase     = PH_SENDER;
            end
            PH_SENDER: begin
               state_next.header_sender = rx_byte;
               state_next.phase         = PH_LENGTH;
            end
            PH_LENGTH: begin
               state_next.header_length = rx_byte;
               state_next.phase         = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               result.data_valid     = 1'b1;
               result.data_index     = state.data_count;
               result.data_byte      = rx_byte;
               state_next.data_sum   = state.data_sum + rx_byte;
               state_next.data_count = count_inc;
               if (count_inc == state.header_length) begin
                  state_next.phase = PH_CHECK;
               end
            end
            PH_CHECK: begin
               state_next.phase = PH_WAIT;
               if (SUM_BASE - state.data_sum == rx_byte) begin
                  result.response = RESP_PACKET;
               end
            end
            default: begin
               state_next.phase = PH_WAIT;
            end
         endcase
      end
      result.packet_op     = state_next.header_op;
      result.packet_sender = state_next.header_sender;
      result.packet_length = state_next.header_length;
   end

endmodule

### hw/rtl/packet_and_word_stream_parser.sv
// ----------------------------------------------------------------------------
// packet_and_word_stream_parser
// Byte-serial deframer for checksummed packets and plain alphanumeric words.
// An accepted byte waits in the input register; its result beat is registered
// in the output register on rsp_bus. Throughput: 1 byte per cycle unless
// rsp_bus stalls; one byte's state update is a single pass through the step
// logic between the input and result registers. Reset: synchronous, active
// high; clears the valid flags of both registers and the parser state.
// ----------------------------------------------------------------------------
module packet_and_word_stream_parser (
   input  logic        clock,
   input  logic        reset,
   pwsp_req_if.sink    req_bus,
   pwsp_rsp_if.source  rsp_bus
);
   import pwsp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   state_type  state_ff, state_in;
   state_type  state_next;
   result_type result;
   logic       advance;

   pwsp_step u_step (
      .state      (state_ff),
      .rx_byte    (in_byte_ff),
      .state_next (state_next),
      .result     (result)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.rx_byte;
      end
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
         state_in     = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.response        = out_ff.response;
   assign rsp_bus.packet_op       = out_ff.packet_op;
   assign rsp_bus.packet_sender   = out_ff.packet_sender;
   assign rsp_bus.packet_length   = out_ff.packet_length;
   assign rsp_bus.data_valid      = out_ff.data_valid;
   assign rsp_bus.data_index      = out_ff.data_index;
   assign rsp_bus.data_byte       = out_ff.data_byte;
   assign rsp_bus.word_char_valid = out_ff.word_char_valid;
   assign rsp_bus.word_index      = out_ff.word_index;
   assign rsp_bus.word_char       = out_ff.word_char;
   assign rsp_bus.word_length     = out_ff.word_length;

endmodule

### hw/rtl/pwsp_checker.sv
// ----------------------------------------------------------------------------
// pwsp_checker
// Port-level checks on parser result beats, bound to the top level.
// ----------------------------------------------------------------------------
module pwsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [1:0] response,
   input logic [7:0] packet_op,
   input logic [7:0] packet_sender,
   input logic [7:0] packet_length,
   input logic       data_valid,
   input logic       word_char_valid,
   input logic [5:0] word_length
);
   import pwsp_pkg::*;

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a byte is never both a data byte and a word character
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(data_valid && word_char_valid))
      else $error("data byte and word character in one beat");

   // a start beat shows a cleared header
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && response == RESP_START |->
         packet_op == 8'd0 && packet_sender == 8'd0 && packet_length == 8'd0)
      else $error("header not cleared on packet start");

   // word length is nonzero exactly on a word-ended beat
   a_word_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((response == RESP_WORD) == (word_length != 6'd0)))
      else $error("word length inconsistent with response");

endmodule

bind packet_and_word_stream_parser pwsp_checker u_pwsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .response        (rsp_bus.response),
   .packet_op       (rsp_bus.packet_op),
   .packet_sender   (rsp_bus.packet_sender),
   .packet_length   (rsp_bus.packet_length),
   .data_valid      (rsp_bus.data_valid),
   .word_char_valid (rsp_bus.word_char_valid),
   .word_length     (rsp_bus.word_length)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and hand-picked byte streams into the packet and word stream
// parser and checks every result beat against a predicted copy of the parse
// state: packet header fields, streamed data bytes, checksum verdicts, word
// characters, word saturation and word end. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import pwsp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 900;

   class deframe_scoreboard;
      logic [2:0] phase;
      logic [7:0] sum;
      logic [7:0] count;
      logic [7:0] op;
      logic [7:0] sender;
      logic [7:0] length;
      logic [5:0] word_count;
      result_type pending_results[$];
      int beats = 0;
      int errors = 0;
      int n_starts = 0;
      int n_good = 0;
      int n_bad = 0;
      int n_words = 0;
      int n_dropped = 0;

      function new();
         phase = PH_WAIT;
         sum = '0;
         count = '0;
         op = '0;
         sender = '0;
         length = '0;
         word_count = '0;
      endfunction

      function bit is_word_char(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z");
      endfunction

      function void note_rx_byte(logic [7:0] c);
         result_type r;
         logic [7:0] want;
         r = '0;
         if (phase != PH_CHECK && c == START_BYTE) begin
            phase = PH_OP;
            sum = '0;
            count = '0;
            op = '0;
            sender = '0;
            length = '0;
            word_count = '0;
            r.response = RESP_START;
            n_starts++;
         end else begin
            case (phase)
               PH_WAIT: begin
                  if (is_word_char(c)) begin
                     r.word_char_valid = 1'b1;
                     r.word_char = c;
                     word_count = 6'd1;
                     phase = PH_WORD;
                  end
               end
               PH_WORD: begin
                  if (is_word_char(c)) begin
                     if (word_count < WORD_MAX) begin
                        r.word_char_valid = 1'b1;
                        r.word_index = word_count[4:0];
                        r.word_char = c;
                        word_count++;
                     end else begin
                        n_dropped++;
                     end
                  end else begin
                     r.response = RESP_WORD;
                     r.word_length = word_count;
                     word_count = '0;
                     phase = PH_WAIT;
                     n_words++;
                  end
               end
               PH_OP: begin
                  op = c;
                  phase = PH_SENDER;
               end
               PH_SENDER: begin
                  sender = c;
                  phase = PH_LENGTH;
               end
               PH_LENGTH: begin
                  length = c;
                  phase = (c == 8'd0) ? PH_CHECK : PH_DATA;
               end
               PH_DATA: begin
                  r.data_valid = 1'b1;
                  r.data_index = count;
                  r.data_byte = c;
                  sum = sum + c;
                  count = count + 8'd1;
                  if (count == length) phase = PH_CHECK;
               end
               PH_CHECK: begin
                  phase = PH_WAIT;
                  want = SUM_BASE - sum;
                  if (want == c) begin
                     r.response = RESP_PACKET;
                     n_good++;
                  end else begin
                     n_bad++;
                  end
               end
               default: phase = PH_WAIT;
            endcase
         end
         r.packet_op = op;
         r.packet_sender = sender;
         r.packet_length = length;
         pending_results.push_back(r);
      endfunction

      function void compare(string name, logic [31:0] e, logic [31:0] a);
         if (a !== e) begin
            if (errors < 10)
               $display("beat %0d: %s expected 0x%0h, got 0x%0h", beats, name, e, a);
            errors++;
         end
      endfunction

      function void check_beat(result_type got);
         result_type e;
         if (pending_results.size() == 0) begin
            if (errors < 10) $display("beat %0d: result with nothing expected", beats);
            errors++;
         end else begin
            e = pending_results.pop_front();
            compare("response", 32'(e.response), 32'(got.response));
            compare("packet_op", 32'(e.packet_op), 32'(got.packet_op));
            compare("packet_sender", 32'(e.packet_sender), 32'(got.packet_sender));
            compare("packet_length", 32'(e.packet_length), 32'(got.packet_length));
            compare("data_valid", 32'(e.data_valid), 32'(got.data_valid));
            compare("data_index", 32'(e.data_index), 32'(got.data_index));
            compare("data_byte", 32'(e.data_byte), 32'(got.data_byte));
            compare("word_char_valid", 32'(e.word_char_valid),
                    32'(got.word_char_valid));
            compare("word_index", 32'(e.word_index), 32'(got.word_index));
            compare("word_char", 32'(e.word_char), 32'(got.word_char));
            compare("word_length", 32'(e.word_length), 32'(got.word_length));
         end
         beats++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int cycles = 0;
   int n_sent = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   deframe_scoreboard sb;
   result_type seen;

   pwsp_req_if req_bus ();
   pwsp_rsp_if rsp_bus ();

   packet_and_word_stream_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // result side: check accepted beats, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.response = rsp_bus.response;
         seen.packet_op = rsp_bus.packet_op;
         seen.packet_sender = rsp_bus.packet_sender;
         seen.packet_length = rsp_bus.packet_length;
         seen.data_valid = rsp_bus.data_valid;
         seen.data_index = rsp_bus.data_index;
         seen.data_byte = rsp_bus.data_byte;
         seen.word_char_valid = rsp_bus.word_char_valid;
         seen.word_index = rsp_bus.word_index;
         seen.word_char = rsp_bus.word_char;
         seen.word_length = rsp_bus.word_length;
         sb.check_beat(seen);
      end
      if (stall_left != 0)
         stall_left--;
      else if (!quiet && $urandom_range(0, 6) == 0)
         stall_left = $urandom_range(1, 13);
      rsp_bus.ready <= (stall_left == 0);
   end

   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_rx_byte(b);
      n_sent++;
   endtask

   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0] directed_bytes[$] = '{
         8'h2F, 8'h30, 8'h5A, 8'h61, 8'h39, 8'h41, 8'h7A, 8'h7B,
         8'h71, 8'h51, START_BYTE,
         8'hFF, 8'h00, 8'h00, 8'hFF,
         START_BYTE, 8'h00, 8'hFF, 8'h01, 8'h81, START_BYTE,
         START_BYTE, 8'h01, 8'h02, 8'h00, 8'h00
      };
      int choice;
      int len;
      int k;
      bit drained_mid;
      logic [7:0] run_sum;
      logic [7:0] b;

      drained_mid = 1'b0;
      sb = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // words at the character class edges, start byte inside a word,
      // zero length packet, start byte as checksum, bad checksum
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_all_results();

      while (n_sent < directed_bytes.size() + RANDOM_BYTES) begin
         if (n_sent >= 800) quiet = 1'b1;
         if (!drained_mid && n_sent >= 450) begin
            wait_all_results();
            drained_mid = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 55) begin
            // packet, mostly short, occasionally near full length; some carry start bytes in the data or a bad checksum
            k = $urandom_range(0, 39);
            if (k == 0) len = $urandom_range(200, 255);
            else if (k < 4) len = 0;
            else len = $urandom_range(1, 12);
            send_byte(START_BYTE);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(len[7:0]);
            run_sum = '0;
            for (int i = 0; i < len; i++) begin
               b = ($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
               run_sum = run_sum + b;
               send_byte(b);
            end
            if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_byte(SUM_BASE - run_sum);
         end else if (choice < 85) begin
            // plain word, sometimes past the length limit
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               k = $urandom_range(0, 61);
               b = 8'((k < 10) ? 'h30 + k : (k < 36) ? 'h41 + k - 10 : 'h61 + k - 36);
               send_byte(b);
            end
            if ($urandom_range(0, 9) == 0) begin
               send_byte(START_BYTE);
            end else begin
               do b = 8'($urandom_range(0, 255));
               while (sb.is_word_char(b) || b == START_BYTE);
               send_byte(b);
            end
         end else if (choice < 93) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
         end else begin
            // packet cut short, the next start byte or noise takes over
            send_byte(START_BYTE);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
         end
      end

      wait_all_results();
      repeat (10) @(posedge clock);

      $display("covered %0d bytes: %0d packet starts, %0d good and %0d bad checksums",
               n_sent, sb.n_starts, sb.n_good, sb.n_bad);
      $display("%0d words ended, %0d characters dropped past the word limit, %0d mismatches",
               sb.n_words, sb.n_dropped, sb.errors);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/pwsp_pkg.sv
hw/rtl/pwsp_if.sv
hw/rtl/pwsp_step.sv
hw/rtl/packet_and_word_stream_parser.sv
hw/rtl/pwsp_checker.sv
tb/testbench.sv
